/* hdl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, widths and constants of the preconditioning scale pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Pipeline geometry
  localparam int FRONT_LAT  = 3;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int LOG_FRAC   = 27;
  // normalize, two stages per squaring, three for difference/scale/round
  localparam int LOG_LAT    = 2 * LOG_FRAC + 4;
  localparam int ARITH_LAT  = FRONT_LAT + DIV_STEPS + SQRT_STEPS;
  localparam int LOG_ALIGN  = ARITH_LAT - LOG_LAT;
  localparam int SAT_ALIGN  = ARITH_LAT - FRONT_LAT;

  // Constants
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam logic [31:0] DATA_SIGMA_RST = 32'd16777216;
  localparam logic [30:0] SKIP_ONE       = 31'h4000_0000;
  localparam logic [31:0] IN_SAT         = 32'hFFFF_FFFF;
  localparam logic [31:0] NOISE_MIN      = 32'h8000_0000;
  localparam logic [31:0] NOISE_MAX      = 32'h7FFF_FFFF;

  // One restoring divider lane: partial remainder and a word that shifts
  // numerator bits out at the top and quotient bits in at the bottom
  typedef struct packed {
    logic [64:0] rem;
    logic [63:0] nq;
  } div_lane_t;

endpackage

/* hdl/psc_ifs.sv */
// ----------------------------------------------------------------------------
// psc channel interfaces
// Request channels of the preconditioning block: sigma in, scales out, and
// the data sigma configuration write.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sigma;
  modport source (output valid, output sigma, input ready);
  modport sink   (input valid, input sigma, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] skip_scale;
  logic        [31:0] out_scale;
  logic        [31:0] in_scale;
  logic signed [31:0] noise_cond;
  logic               sigma_zero;
  modport source (output valid, output skip_scale, output out_scale, output in_scale,
                  output noise_cond, output sigma_zero, input ready);
  modport sink   (input valid, input skip_scale, input out_scale, input in_scale,
                  input noise_cond, input sigma_zero, output ready);
endinterface

interface psc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/psc_delay.sv */
// ----------------------------------------------------------------------------
// psc_delay
// Enabled shift line that aligns a side value with the main pipeline.
// ----------------------------------------------------------------------------
module psc_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [DEPTH];

  // Advance all taps together
  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) sh_r[0] <= din;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign dout = sh_r[DEPTH-1];

endmodule

/* hdl/psc_front.sv */
// ----------------------------------------------------------------------------
// psc_front
// Squares and cross product, sum of squares, and the starting remainders
// of the three divisions.
// ----------------------------------------------------------------------------
module psc_front #(
  parameter int SIGMA_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        sigma,
  input  logic [31:0]        data_sigma,
  output logic [64:0]        sum_o,
  output psc_pkg::div_lane_t skip_o,
  output psc_pkg::div_lane_t outs_o,
  output psc_pkg::div_lane_t ins_o,
  output logic               ins_sat_o
);
  import psc_pkg::*;

  localparam int          INS_EXP  = 2 * SIGMA_FRAC_BITS - 10;
  localparam logic [64:0] INS_HIGH = 65'd1 << INS_EXP;

  logic [63:0]  s2_r, d2_r, p_r;
  logic [64:0]  sum_r;
  logic [63:0]  d2b_r, hh_r, hl_r, ll_r;
  logic [127:0] p2;
  logic [64:0]  sum_c_r;
  div_lane_t    skip_r, outs_r, ins_r;
  logic         ins_sat_r;

  // Stage A: products of the codes
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= sigma * sigma;
      d2_r <= data_sigma * data_sigma;
      p_r  <= sigma * data_sigma;
    end
  end

  // Stage B: sum of squares, partial products of the cross product square
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= {1'b0, s2_r} + {1'b0, d2_r};
      d2b_r <= d2_r;
      hh_r  <= p_r[63:32] * p_r[63:32];
      hl_r  <= p_r[63:32] * p_r[31:0];
      ll_r  <= p_r[31:0] * p_r[31:0];
    end
  end

  // Stage C: combine partial products, set up divider lanes
  assign p2 = {hh_r, 64'b0} + {31'b0, hl_r, 33'b0} + {64'b0, ll_r};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_c_r     <= sum_r;
      skip_r.rem  <= {35'b0, d2b_r[63:34]};
      skip_r.nq   <= {d2b_r[33:0], 30'b0};
      outs_r.rem  <= {1'b0, p2[127:64]};
      outs_r.nq   <= p2[63:0];
      ins_r.rem   <= INS_HIGH;
      ins_r.nq    <= 64'b0;
      ins_sat_r   <= (INS_HIGH >= sum_r);
    end
  end

  assign sum_o     = sum_c_r;
  assign skip_o    = skip_r;
  assign outs_o    = outs_r;
  assign ins_o     = ins_r;
  assign ins_sat_o = ins_sat_r;

endmodule

/* hdl/psc_div.sv */
// ----------------------------------------------------------------------------
// psc_div
// Three restoring dividers by the sum of squares, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic               clk,
  input  logic               en,
  input  logic [64:0]        sum_i,
  input  psc_pkg::div_lane_t skip_i,
  input  psc_pkg::div_lane_t outs_i,
  input  psc_pkg::div_lane_t ins_i,
  output logic [63:0]        skip_q_o,
  output logic [63:0]        outs_q_o,
  output logic [63:0]        ins_q_o
);
  import psc_pkg::*;

  logic [64:0] sum_r  [DIV_STEPS-1];
  logic [64:0] sum_in [DIV_STEPS];
  div_lane_t   skip_r [DIV_STEPS];
  div_lane_t   outs_r [DIV_STEPS];
  div_lane_t   ins_r  [DIV_STEPS];
  div_lane_t   skip_in [DIV_STEPS];
  div_lane_t   outs_in [DIV_STEPS];
  div_lane_t   ins_in  [DIV_STEPS];

  // One compare and subtract: bring down the next numerator bit
  function automatic div_lane_t div_step(input div_lane_t ln, input logic [64:0] dv);
    logic [65:0] trial;
    logic [65:0] diff;
    logic        ge;
    div_lane_t   res;
    trial   = {ln.rem, ln.nq[63]};
    ge      = (trial >= {1'b0, dv});
    diff    = trial - {1'b0, dv};
    res.rem = ge ? diff[64:0] : trial[64:0];
    res.nq  = {ln.nq[62:0], ge};
    return res;
  endfunction

  assign sum_in[0]  = sum_i;
  assign skip_in[0] = skip_i;
  assign outs_in[0] = outs_i;
  assign ins_in[0]  = ins_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k > 0) begin : g_link
      assign sum_in[k]  = sum_r[k-1];
      assign skip_in[k] = skip_r[k-1];
      assign outs_in[k] = outs_r[k-1];
      assign ins_in[k]  = ins_r[k-1];
    end

    // Advance one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        skip_r[k] <= div_step(skip_in[k], sum_in[k]);
        outs_r[k] <= div_step(outs_in[k], sum_in[k]);
        ins_r[k]  <= div_step(ins_in[k], sum_in[k]);
      end
    end

    if (k < DIV_STEPS - 1) begin : g_sum
      always_ff @(posedge clk) begin
        if (en) sum_r[k] <= sum_in[k];
      end
    end
  end

  assign skip_q_o = skip_r[DIV_STEPS-1].nq;
  assign outs_q_o = outs_r[DIV_STEPS-1].nq;
  assign ins_q_o  = ins_r[DIV_STEPS-1].nq;

endmodule

/* hdl/psc_isqrt.sv */
// ----------------------------------------------------------------------------
// psc_isqrt
// Two 64-bit integer square roots, one result bit per stage.
// ----------------------------------------------------------------------------
module psc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [31:0] a_root_o,
  output logic [31:0] b_root_o
);
  import psc_pkg::*;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sqrt_lane_t;

  sqrt_lane_t a_r  [SQRT_STEPS];
  sqrt_lane_t b_r  [SQRT_STEPS];
  sqrt_lane_t a_in [SQRT_STEPS];
  sqrt_lane_t b_in [SQRT_STEPS];

  // Try one root bit against the remaining radicand
  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t ln, input logic [63:0] bv);
    logic [63:0] t;
    sqrt_lane_t  res;
    t = ln.r + bv;
    if (ln.v >= t) begin
      res.v = ln.v - t;
      res.r = (ln.r >> 1) + bv;
    end else begin
      res.v = ln.v;
      res.r = ln.r >> 1;
    end
    return res;
  endfunction

  assign a_in[0] = '{v: a_i, r: 64'b0};
  assign b_in[0] = '{v: b_i, r: 64'b0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);

    if (k > 0) begin : g_link
      assign a_in[k] = a_r[k-1];
      assign b_in[k] = b_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k] <= sqrt_step(a_in[k], BIT_K);
        b_r[k] <= sqrt_step(b_in[k], BIT_K);
      end
    end
  end

  assign a_root_o = a_r[SQRT_STEPS-1].r[31:0];
  assign b_root_o = b_r[SQRT_STEPS-1].r[31:0];

endmodule

/* hdl/psc_log.sv */
// ----------------------------------------------------------------------------
// psc_log
// Quarter natural log of sigma over data sigma: base-2 logs by repeated
// squaring, then the difference scaled by ln 2 with rounding.
// ----------------------------------------------------------------------------
module psc_log (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sigma,
  input  logic [31:0] data_sigma,
  output logic [31:0] noise_o
);
  import psc_pkg::*;

  typedef struct packed {
    logic [4:0]          n;
    logic [LOG_FRAC-1:0] frac;
    logic [62:0]         y;
  } log_lane_t;

  typedef struct packed {
    logic [4:0]          n;
    logic [LOG_FRAC-1:0] frac;
    logic [61:0]         hh;
    logic [62:0]         hl;
    logic [63:0]         ll;
  } log_prod_t;

  log_lane_t   s_lane_r [LOG_FRAC+1];
  log_lane_t   d_lane_r [LOG_FRAC+1];
  log_prod_t   s_prod_r [LOG_FRAC];
  log_prod_t   d_prod_r [LOG_FRAC];
  logic [31:0] ls, ld;
  logic        neg1_r, neg2_r;
  logic [31:0] mag_r;
  logic [61:0] scl_r;
  logic [62:0] rnd;
  logic [31:0] qv;
  logic [31:0] noise_r;

  // Normalize so the leading one sits at bit 62
  function automatic log_lane_t log_norm(input logic [31:0] x);
    logic [4:0]  n;
    logic [63:0] sh;
    log_lane_t   res;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 5'(i);
    end
    sh       = {32'b0, x} << (6'd62 - {1'b0, n});
    res.n    = n;
    res.frac = '0;
    res.y    = sh[62:0];
    return res;
  endfunction

  function automatic log_prod_t log_mul(input log_lane_t ln);
    log_prod_t res;
    res.n    = ln.n;
    res.frac = ln.frac;
    res.hh   = ln.y[62:32] * ln.y[62:32];
    res.hl   = ln.y[62:32] * ln.y[31:0];
    res.ll   = ln.y[31:0] * ln.y[31:0];
    return res;
  endfunction

  // Rebuild the square, take one fraction bit, renormalize
  function automatic log_lane_t log_add(input log_prod_t pr);
    logic [125:0] sq;
    logic [63:0]  yn;
    log_lane_t    res;
    sq       = {pr.hh, 64'b0} + {30'b0, pr.hl, 33'b0} + {62'b0, pr.ll};
    yn       = sq[125:62];
    res.n    = pr.n;
    res.frac = {pr.frac[LOG_FRAC-2:0], yn[63]};
    res.y    = yn[63] ? yn[63:1] : yn[62:0];
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s_lane_r[0] <= log_norm(sigma);
      d_lane_r[0] <= log_norm(data_sigma);
    end
  end

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        s_prod_r[i]   <= log_mul(s_lane_r[i]);
        d_prod_r[i]   <= log_mul(d_lane_r[i]);
        s_lane_r[i+1] <= log_add(s_prod_r[i]);
        d_lane_r[i+1] <= log_add(d_prod_r[i]);
      end
    end
  end

  assign ls = {s_lane_r[LOG_FRAC].n, s_lane_r[LOG_FRAC].frac};
  assign ld = {d_lane_r[LOG_FRAC].n, d_lane_r[LOG_FRAC].frac};

  // Difference magnitude, scale by ln 2, round half away from zero
  assign rnd = {1'b0, scl_r} + 63'h8000_0000;
  assign qv  = {1'b0, rnd[62:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= (ld > ls);
      mag_r   <= (ld > ls) ? (ld - ls) : (ls - ld);
      neg2_r  <= neg1_r;
      scl_r   <= mag_r * LN2_Q30;
      noise_r <= neg2_r ? (32'd0 - qv) : qv;
    end
  end

  assign noise_o = noise_r;

endmodule

/* hdl/diffusion_precondition_scales_top.sv */
// ----------------------------------------------------------------------------
// diffusion_precondition_scales_top
// Diffusion preconditioning scales (skip, output, input, noise) per sigma.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one noise level sigma per request (unsigned, sigma
//   format). out_chan returns one request per sigma with skip_scale,
//   out_scale, in_scale, noise_cond and sigma_zero, in input order.
//   cfg_chan writes data_sigma; it is always ready. The user must write it
//   only while no request is in flight; the block does not enforce this.
// Timing:
//   A new sigma is taken every cycle while out_chan is not stalled. The
//   request passes 3 multiply stages, 64 divider stages (one quotient bit
//   each) and 32 square root stages into the output register, the first
//   stage loading at the accepting edge.
//   The base-2 log path runs in parallel (58 stages) and is delay-aligned.
// Reset and stall:
//   rst_n (synchronous) empties the pipeline and loads data_sigma with 16.0.
//   While a result waits on out_chan the whole pipeline holds, in_chan.ready
//   drops once the output register is full and not taken; nothing is lost.
// ----------------------------------------------------------------------------
module diffusion_precondition_scales_top #(
  parameter int SIGMA_FRAC_BITS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  psc_in_if.sink    in_chan,
  psc_out_if.source out_chan,
  psc_cfg_if.sink   cfg_chan
);
  import psc_pkg::*;

  logic [31:0]         data_sigma_r;
  logic                adv;
  logic [ARITH_LAT-1:0] vld_r;
  logic                out_valid_r;

  logic [64:0] sum;
  div_lane_t   skip_ln, outs_ln, ins_ln;
  logic        ins_sat;
  logic [63:0] skip_q, outs_q, ins_q;
  logic [31:0] outs_root, ins_root;
  logic [30:0] skip_d;
  logic [31:0] noise_raw, noise_d;
  logic        sz_d, sat_d;
  logic        d_zero, sum_zero;

  logic [30:0] skip_r;
  logic [31:0] outs_r, ins_r, noise_r;
  logic        sz_r;

  // Hold everything while the output request is not taken
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_sigma_r <= DATA_SIGMA_RST;
    end else if (cfg_chan.valid) begin
      data_sigma_r <= cfg_chan.data;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[ARITH_LAT-2:0], in_chan.valid};
      out_valid_r <= vld_r[ARITH_LAT-1];
    end
  end

  psc_front #(.SIGMA_FRAC_BITS(SIGMA_FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (adv),
    .sigma      (in_chan.sigma),
    .data_sigma (data_sigma_r),
    .sum_o      (sum),
    .skip_o     (skip_ln),
    .outs_o     (outs_ln),
    .ins_o      (ins_ln),
    .ins_sat_o  (ins_sat)
  );

  psc_div u_div (
    .clk      (clk),
    .en       (adv),
    .sum_i    (sum),
    .skip_i   (skip_ln),
    .outs_i   (outs_ln),
    .ins_i    (ins_ln),
    .skip_q_o (skip_q),
    .outs_q_o (outs_q),
    .ins_q_o  (ins_q)
  );

  psc_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .a_i      (outs_q),
    .b_i      (ins_q),
    .a_root_o (outs_root),
    .b_root_o (ins_root)
  );

  psc_delay #(.W(31), .DEPTH(SQRT_STEPS)) u_skip_dly (
    .clk (clk), .en (adv), .din (skip_q[30:0]), .dout (skip_d)
  );

  psc_log u_log (
    .clk        (clk),
    .en         (adv),
    .sigma      (in_chan.sigma),
    .data_sigma (data_sigma_r),
    .noise_o    (noise_raw)
  );

  psc_delay #(.W(32), .DEPTH(LOG_ALIGN)) u_noise_dly (
    .clk (clk), .en (adv), .din (noise_raw), .dout (noise_d)
  );

  psc_delay #(.W(1), .DEPTH(ARITH_LAT)) u_sz_dly (
    .clk (clk), .en (adv), .din (in_chan.sigma == 32'd0), .dout (sz_d)
  );

  psc_delay #(.W(1), .DEPTH(SAT_ALIGN)) u_sat_dly (
    .clk (clk), .en (adv), .din (ins_sat), .dout (sat_d)
  );

  // Special cases: zero sigma, zero data sigma, both zero
  assign d_zero   = (data_sigma_r == 32'd0);
  assign sum_zero = sz_d && d_zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      skip_r  <= sum_zero ? SKIP_ONE : skip_d;
      outs_r  <= sum_zero ? 32'd0 : outs_root;
      ins_r   <= (sum_zero || sat_d) ? IN_SAT : ins_root;
      noise_r <= sz_d ? NOISE_MIN : (d_zero ? NOISE_MAX : noise_d);
      sz_r    <= sz_d;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.skip_scale = skip_r;
  assign out_chan.out_scale  = outs_r;
  assign out_chan.in_scale   = ins_r;
  assign out_chan.noise_cond = noise_r;
  assign out_chan.sigma_zero = sz_r;

endmodule
